@@ design/prt_pkg.sv @@
// Package for the pending request table.
// Holds request, result and table entry types, status and key codes, and the key compare.
// Used by prt_engine and pending_request_table_top in the design folder.
package prt_pkg;

    localparam int PRT_SLOTS = 256;

    localparam logic       OP_STORE   = 1'b0;
    localparam logic       OP_REPLY   = 1'b1;

    localparam logic [1:0] KEY_FS     = 2'd0;
    localparam logic [1:0] KEY_DEV    = 2'd1;

    localparam logic [1:0] ST_STORED  = 2'd0;
    localparam logic [1:0] ST_REPLIED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_NOMATCH = 2'd3;

    typedef struct packed {
        logic               op;
        logic [1:0]         key_type;
        logic [15:0]        requester_pid;
        logic [15:0]        owner_pid;
        logic [15:0]        device_id;
        logic [31:0]        msg_handle;
        logic [15:0]        source_pid;
        logic signed [31:0] reply_value;
    } t_req_in;

    typedef struct packed {
        logic [1:0]         status;
        logic [7:0]         slot;
        logic [31:0]        reply_handle;
        logic [15:0]        reply_dest;
        logic signed [31:0] reply_result;
    } t_result;

    typedef struct packed {
        logic        valid;
        logic [1:0]  key_type;
        logic [15:0] requester_pid;
        logic [15:0] owner_pid;
        logic [15:0] device_id;
        logic [31:0] handle;
        logic [15:0] source;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    function automatic logic key_hit(t_entry e, t_req_in q);
        logic hit;
        hit = 1'b0;
        if (e.key_type == q.key_type) begin
            case (q.key_type)
                KEY_FS:  hit = (e.requester_pid == q.requester_pid);
                KEY_DEV: hit = (e.requester_pid == q.requester_pid) &&
                               (e.owner_pid == q.owner_pid) &&
                               (e.device_id == q.device_id);
                default: hit = 1'b0;
            endcase
        end
        return hit;
    endfunction

endpackage

@@ design/prt_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module prt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/prt_engine.sv @@
// Scan engine: clears the table after reset, then walks slots through the RAM read port
// to find a free slot or a matching key, and writes the entry back. Depends on prt_pkg.
module prt_engine #(
    parameter int SLOTS = prt_pkg::PRT_SLOTS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  prt_pkg::t_req_in         i_req,
    output logic                     o_busy,
    output logic                     o_done,
    output prt_pkg::t_result         o_result,
    output logic [$clog2(SLOTS)-1:0] o_raddr,
    input  prt_pkg::t_entry          i_rdata,
    output logic                     o_we,
    output logic [$clog2(SLOTS)-1:0] o_waddr,
    output prt_pkg::t_entry          o_wdata
);
    import prt_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int CW = AW + 1;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_SCAN  = 3'b100
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_chk, n_chk;
    logic [AW-1:0] r_chk_idx, n_chk_idx;
    t_req_in       r_req, n_req;
    logic          r_done, n_done;
    t_result       r_result, n_result;

    logic          hit;
    logic          last;
    t_entry        new_entry;
    t_entry        freed_entry;

    always_comb begin
        new_entry               = '0;
        new_entry.valid         = 1'b1;
        new_entry.key_type      = r_req.key_type;
        new_entry.requester_pid = r_req.requester_pid;
        new_entry.owner_pid     = r_req.owner_pid;
        new_entry.device_id     = r_req.device_id;
        new_entry.handle        = r_req.msg_handle;
        new_entry.source        = r_req.source_pid;
        freed_entry             = i_rdata;
        freed_entry.valid       = 1'b0;
    end

    assign hit  = (r_req.op == OP_STORE) ? !i_rdata.valid
                                         : (i_rdata.valid && key_hit(i_rdata, r_req));
    assign last = (r_chk_idx == AW'(SLOTS - 1));

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_chk     = 1'b0;
        n_chk_idx = r_chk_idx;
        n_req     = r_req;
        n_done    = 1'b0;
        n_result  = r_result;
        o_raddr   = r_cnt[AW-1:0];
        o_we      = 1'b0;
        o_waddr   = r_chk_idx;
        o_wdata   = new_entry;

        unique case (r_state)
            S_CLEAR: begin
                o_we    = 1'b1;
                o_waddr = r_cnt[AW-1:0];
                o_wdata = '0;
                n_cnt   = r_cnt + CW'(1);
                if (r_cnt == CW'(SLOTS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_req   = i_req;
                    n_cnt   = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_cnt != CW'(SLOTS)) begin
                    n_chk     = 1'b1;
                    n_chk_idx = r_cnt[AW-1:0];
                    n_cnt     = r_cnt + CW'(1);
                end
                if (r_chk && hit) begin
                    o_we     = 1'b1;
                    o_wdata  = (r_req.op == OP_STORE) ? new_entry : freed_entry;
                    n_result = '0;
                    n_result.slot = 8'(r_chk_idx);
                    if (r_req.op == OP_STORE) begin
                        n_result.status = ST_STORED;
                    end else begin
                        n_result.status       = ST_REPLIED;
                        n_result.reply_handle = i_rdata.handle;
                        n_result.reply_dest   = i_rdata.source;
                        n_result.reply_result = r_req.reply_value;
                    end
                    n_done  = 1'b1;
                    n_chk   = 1'b0;
                    n_state = S_IDLE;
                end else if (r_chk && last) begin
                    n_result        = '0;
                    n_result.status = (r_req.op == OP_STORE) ? ST_FULL : ST_NOMATCH;
                    n_done          = 1'b1;
                    n_chk           = 1'b0;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
            r_chk   <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_chk   <= n_chk;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_idx <= n_chk_idx;
        r_req     <= n_req;
        r_result  <= n_result;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

@@ design/pending_request_table_top.sv @@
// Pending request table: a request that settles at slot k gives its result once the scan
// reaches slot k; a full table or a missing match gives its result once the scan passes the
// last slot. One request at a time: no new request is accepted before the last result is out,
// as the scan reads the table RAM one slot per cycle. Results cannot be stalled. Reset
// (synchronous, active low) starts a clearing pass over every slot with busy held high.
// Depends on prt_pkg, prt_engine, prt_ram.
module pending_request_table_top #(
    parameter int SLOTS = prt_pkg::PRT_SLOTS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  prt_pkg::t_req_in i_req,
    output logic             o_done,
    output prt_pkg::t_result o_result
);
    import prt_pkg::*;

    localparam int AW = $clog2(SLOTS);

    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    logic          we;
    t_entry        rdata;
    t_entry        wdata;

    prt_engine #(
        .SLOTS (SLOTS)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_req    (i_req),
        .o_busy   (busy),
        .o_done   (o_done),
        .o_result (o_result),
        .o_raddr  (raddr),
        .i_rdata  (rdata),
        .o_we     (we),
        .o_waddr  (waddr),
        .o_wdata  (wdata)
    );

    prt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for pending_request_table_top: drives store and reply requests
// through the start/busy handshake and checks every strobed result against a table predictor.
// Depends on prt_pkg and the design folder.
module tb_top;
    import prt_pkg::*;

    localparam int SLOTS = PRT_SLOTS;
    localparam int LIMIT = 2_000_000;

    typedef struct {
        t_req_in req;
        int      idle_pct;
        bit      drain;
    } t_backlog_item;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    t_req_in i_req = '0;
    logic    o_done;
    t_result o_result;

    t_backlog_item req_backlog[$];
    t_result       due_results[$];
    t_req_in       live_keys[$];

    bit      tbl_valid[SLOTS];
    t_req_in tbl_entry[SLOTS];

    int mismatch_count = 0;
    int cycle_count = 0;
    int n_stored = 0;
    int n_replied = 0;
    int n_full = 0;
    int n_nomatch = 0;

    pending_request_table_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_result settle_request(t_req_in r);
        t_result res;
        bit      found;
        bit      hit;
        res = '0;
        found = 1'b0;
        if (r.op == OP_STORE) begin
            res.status = ST_FULL;
            for (int i = 0; i < SLOTS; i++) begin
                if (!found && !tbl_valid[i]) begin
                    found = 1'b1;
                    tbl_valid[i] = 1'b1;
                    tbl_entry[i] = r;
                    res.status = ST_STORED;
                    res.slot = 8'(i);
                end
            end
        end else begin
            res.status = ST_NOMATCH;
            for (int i = 0; i < SLOTS; i++) begin
                if (!found && tbl_valid[i] && tbl_entry[i].key_type == r.key_type) begin
                    hit = 1'b0;
                    if (r.key_type == KEY_FS) begin
                        hit = tbl_entry[i].requester_pid == r.requester_pid;
                    end else if (r.key_type == KEY_DEV) begin
                        hit = tbl_entry[i].requester_pid == r.requester_pid &&
                              tbl_entry[i].owner_pid == r.owner_pid &&
                              tbl_entry[i].device_id == r.device_id;
                    end
                    if (hit) begin
                        found = 1'b1;
                        tbl_valid[i] = 1'b0;
                        res.status = ST_REPLIED;
                        res.slot = 8'(i);
                        res.reply_handle = tbl_entry[i].msg_handle;
                        res.reply_dest = tbl_entry[i].source_pid;
                        res.reply_result = r.reply_value;
                    end
                end
            end
        end
        return res;
    endfunction

    function automatic t_req_in make_req(logic op, logic [1:0] kt, logic [15:0] rq,
                                         logic [15:0] own, logic [15:0] dev,
                                         logic [31:0] handle, logic [15:0] src,
                                         logic [31:0] value);
        t_req_in r;
        r.op = op;
        r.key_type = kt;
        r.requester_pid = rq;
        r.owner_pid = own;
        r.device_id = dev;
        r.msg_handle = handle;
        r.source_pid = src;
        r.reply_value = value;
        return r;
    endfunction

    function automatic logic [15:0] pick_pid();
        logic [15:0] v;
        case ($urandom_range(7))
            0: v = 16'h0000;
            1: v = 16'h0001;
            2: v = 16'h8000;
            3: v = 16'hFFFF;
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    task automatic queue_req(t_req_in r, int idle_pct, bit drain);
        t_backlog_item it;
        it.req = r;
        it.idle_pct = idle_pct;
        it.drain = drain;
        req_backlog.push_back(it);
    endtask

    task automatic queue_random(int count, int store_pct, int idle_pct, bit drain_first);
        t_req_in r;
        int      kind;
        int      idx;
        for (int n = 0; n < count; n++) begin
            r = make_req(1'($urandom), 2'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom), $urandom, 16'($urandom), $urandom);
            if (store_pct == 0 || store_pct == 100 || $urandom_range(9) != 0) begin
                r.op = ($urandom_range(99) < store_pct) ? OP_STORE : OP_REPLY;
                kind = $urandom_range(9);
                r.key_type = (kind < 4) ? KEY_FS : (kind < 8) ? KEY_DEV : 2'(kind - 6);
                r.requester_pid = pick_pid();
                r.owner_pid = pick_pid();
                r.device_id = pick_pid();
                if (r.op == OP_STORE) begin
                    live_keys.push_back(r);
                end else if (live_keys.size() != 0 && $urandom_range(99) < 80) begin
                    idx = $urandom_range(live_keys.size() - 1);
                    r.key_type = live_keys[idx].key_type;
                    r.requester_pid = live_keys[idx].requester_pid;
                    if (r.key_type != KEY_FS) begin
                        r.owner_pid = live_keys[idx].owner_pid;
                        r.device_id = live_keys[idx].device_id;
                    end
                    live_keys.delete(idx);
                end
            end
            queue_req(r, idle_pct, drain_first && n == 0);
        end
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : drive_requests
        logic    nxt_start;
        t_req_in nxt_req;
        nxt_start = start;
        nxt_req = i_req;
        if (i_rst_n) begin
            if (start && !busy) begin
                due_results.push_back(settle_request(i_req));
                nxt_start = 1'b0;
            end
            if (!nxt_start && req_backlog.size() != 0) begin
                if (!(req_backlog[0].drain && (due_results.size() != 0 || o_done)) &&
                    $urandom_range(99) >= req_backlog[0].idle_pct) begin
                    nxt_start = 1'b1;
                    nxt_req = req_backlog[0].req;
                    req_backlog.pop_front();
                end
            end
        end
        start <= nxt_start;
        i_req <= nxt_req;
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_done === 1'b1) begin
            case (o_result.status)
                ST_STORED:  n_stored++;
                ST_REPLIED: n_replied++;
                ST_FULL:    n_full++;
                default:    n_nomatch++;
            endcase
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result, status %0d slot %0d", $time,
                         o_result.status, o_result.slot);
                mismatch_count++;
            end else begin
                want = due_results.pop_front();
                check_field("status", 32'(want.status), 32'(o_result.status));
                check_field("slot", 32'(want.slot), 32'(o_result.slot));
                check_field("reply_handle", want.reply_handle, o_result.reply_handle);
                check_field("reply_dest", 32'(want.reply_dest), 32'(o_result.reply_dest));
                check_field("reply_result", want.reply_result, o_result.reply_result);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        queue_req(make_req(OP_STORE, KEY_FS, 16'h0000, 16'h0000, 16'h0000,
                           32'h0000_0000, 16'h0000, 32'h0), 0, 1'b0);
        queue_req(make_req(OP_STORE, KEY_DEV, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                           32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF), 0, 1'b0);
        queue_req(make_req(OP_STORE, 2'd2, 16'h1234, 16'h0000, 16'h0000,
                           32'h0000_0002, 16'h0002, 32'h0), 0, 1'b0);
        queue_req(make_req(OP_STORE, 2'd3, 16'h1234, 16'h5555, 16'hAAAA,
                           32'h0000_0003, 16'h0003, 32'h0), 0, 1'b0);
        queue_req(make_req(OP_REPLY, 2'd2, 16'h1234, 16'h0000, 16'h0000,
                           32'h0, 16'h0, 32'h5), 0, 1'b0);
        queue_req(make_req(OP_REPLY, 2'd3, 16'h1234, 16'h5555, 16'hAAAA,
                           32'h0, 16'h0, 32'h6), 0, 1'b0);
        queue_req(make_req(OP_STORE, KEY_FS, 16'h0000, 16'h0005, 16'h0007,
                           32'h0000_0011, 16'h0022, 32'h0), 0, 1'b0);
        // filesystem keys ignore owner and device; lowest matching slot goes first
        queue_req(make_req(OP_REPLY, KEY_FS, 16'h0000, 16'hFFFF, 16'hFFFF,
                           32'h0, 16'h0, 32'h7FFF_FFFF), 0, 1'b0);
        queue_req(make_req(OP_REPLY, KEY_FS, 16'h0000, 16'h0000, 16'h0000,
                           32'h0, 16'h0, 32'h8000_0000), 0, 1'b0);
        queue_req(make_req(OP_REPLY, KEY_FS, 16'h0000, 16'h0000, 16'h0000,
                           32'h0, 16'h0, 32'h1), 0, 1'b0);
        queue_req(make_req(OP_REPLY, KEY_DEV, 16'hFFFF, 16'hFFFF, 16'hFFFE,
                           32'h0, 16'h0, 32'h2), 0, 1'b0);
        queue_req(make_req(OP_REPLY, KEY_DEV, 16'hFFFF, 16'hFFFE, 16'hFFFF,
                           32'h0, 16'h0, 32'h3), 0, 1'b0);
        queue_req(make_req(OP_REPLY, KEY_DEV, 16'hFFFE, 16'hFFFF, 16'hFFFF,
                           32'h0, 16'h0, 32'h4), 0, 1'b0);
        queue_req(make_req(OP_REPLY, KEY_FS, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                           32'h0, 16'h0, 32'h5), 0, 1'b0);
        queue_req(make_req(OP_REPLY, KEY_DEV, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                           32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF), 0, 1'b0);
        queue_req(make_req(OP_STORE, KEY_DEV, 16'h0000, 16'h0000, 16'h0000,
                           32'hA5A5_5A5A, 16'h8001, 32'h0), 0, 1'b0);
        queue_req(make_req(OP_REPLY, KEY_DEV, 16'h0000, 16'h0000, 16'h0000,
                           32'h0, 16'h0, 32'h0), 0, 1'b0);

        queue_random(200, 50, 0, 1'b0);
        queue_random(200, 50, 66, 1'b1);
        // overflow the table, then send replies to free slots
        queue_random(290, 100, 19, 1'b1);
        queue_random(200, 0, 0, 1'b1);
        queue_random(80, 50, 19, 1'b1);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (req_backlog.size() != 0 || start) @(negedge i_clk);
        while (due_results.size() != 0) @(negedge i_clk);
        repeat (SLOTS + 4) @(negedge i_clk);

        $display("Checked %0d results: %0d stored, %0d replied, %0d table full, %0d unmatched",
                 n_stored + n_replied + n_full + n_nomatch, n_stored, n_replied, n_full,
                 n_nomatch);
        $display("Mismatches found: %0d", mismatch_count);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
